// ===== hdl/c2s_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, angle codes and arctangent table for the spherical converter.
package c2s_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // result field width and packed output word
    localparam int RES_W      = 16;
    localparam int OUT_DATA_W = 3 * RES_W;

    // CORDIC angle accumulator: one unit is 2pi/2^32
    localparam int ACC_W = 32;
    localparam logic [ACC_W-1:0] ACC_ROUND = 32'h0000_8000;
    localparam logic [ACC_W-1:0] ACC_PI    = 32'h8000_0000;

    // binary angle codes, one unit is 2pi/65536
    localparam logic [RES_W-1:0] ANG_ZERO     = 16'd0;
    localparam logic [RES_W-1:0] ANG_HALF_PI  = 16'd16384;
    localparam logic [RES_W-1:0] ANG_PI       = 16'd32768;
    localparam logic [RES_W-1:0] ANG_3HALF_PI = 16'd49152;

    // atan(2^-i) in accumulator units
    localparam logic [ACC_W-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// ===== hdl/c2s_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined two-lane integer square root, one result bit per stage.
module c2s_isqrt #(
    parameter int NB     = 33,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*NB-1:0]   i_v [2],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NB-1:0]     o_root [2],
    output logic [SIDE_W-1:0] o_side
);

    localparam int VW = 2 * NB;
    localparam int RW = NB + 2;

    logic [RW-1:0]     r_rem  [2][NB];
    logic [NB-1:0]     r_q    [2][NB];
    logic [VW-1:0]     r_v    [2][NB];
    logic [NB-1:0]     r_valid;
    logic [SIDE_W-1:0] r_side [NB];

    for (genvar j = 0; j < NB; j++) begin : g_stage
        logic              vld_in;
        logic [SIDE_W-1:0] side_in;

        if (j == 0) begin : g_first
            assign vld_in  = i_valid;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_valid[j-1];
            assign side_in = r_side[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= side_in;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [RW-1:0] rem_in;
            logic [RW-1:0] rem_pre;
            logic [RW-1:0] trial;
            logic [NB-1:0] q_in;
            logic [VW-1:0] v_in;
            logic          geq;
            logic [RW-1:0] n_rem;
            logic [NB-1:0] n_q;

            if (j == 0) begin : g_first
                assign rem_in = '0;
                assign q_in   = '0;
                assign v_in   = i_v[l];
            end else begin : g_next
                assign rem_in = r_rem[l][j-1];
                assign q_in   = r_q[l][j-1];
                assign v_in   = r_v[l][j-1];
            end

            // remainder stays below 2^NB on entry, so the top two bits are zero
            assign rem_pre = {rem_in[NB-1:0], v_in[VW-1 -: 2]};
            assign trial   = {q_in, 2'b01};
            assign geq     = (rem_pre >= trial);
            assign n_rem   = geq ? (rem_pre - trial) : rem_pre;
            assign n_q     = {q_in[NB-2:0], geq};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][j] <= n_rem;
                    r_q[l][j]   <= n_q;
                    r_v[l][j]   <= v_in << 2;
                end
            end
        end
    end

    assign o_valid   = r_valid[NB-1];
    assign o_root[0] = r_q[0][NB-1];
    assign o_root[1] = r_q[1][NB-1];
    assign o_side    = r_side[NB-1];

endmodule

// ===== hdl/c2s_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined two-lane vectoring CORDIC giving rounded 16-bit binary angles.
module c2s_cordic #(
    parameter int STAGES = 16,
    parameter int CW     = 35,
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [CW-1:0]     i_a [2],
    input  logic signed [CW-1:0]     i_b [2],
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic [c2s_pkg::RES_W-1:0] o_angle [2],
    output logic [SIDE_W-1:0]        o_side
);

    import c2s_pkg::*;

    // index 0 is the half-plane fold, index i+1 follows micro-rotation i
    logic signed [CW-1:0] r_a   [2][STAGES+1];
    logic signed [CW-1:0] r_b   [2][STAGES+1];
    logic [ACC_W-1:0]     r_acc [2][STAGES+1];
    logic [STAGES:0]      r_valid;
    logic [SIDE_W-1:0]    r_side [STAGES+1];

    logic [RES_W-1:0]     r_ang [2];
    logic                 r_fvalid;
    logic [SIDE_W-1:0]    r_fside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_fold
        // fold the left half-plane onto the right, starting the angle at pi
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_a[l][CW-1]) begin
                    r_a[l][0]   <= -i_a[l];
                    r_b[l][0]   <= -i_b[l];
                    r_acc[l][0] <= ACC_PI;
                end else begin
                    r_a[l][0]   <= i_a[l];
                    r_b[l][0]   <= i_b[l];
                    r_acc[l][0] <= '0;
                end
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[i+1] <= r_side[i];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [CW-1:0] da;
            logic signed [CW-1:0] db;

            assign da = r_b[l][i] >>> i;
            assign db = r_a[l][i] >>> i;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_b[l][i][CW-1]) begin
                        r_a[l][i+1]   <= r_a[l][i] + da;
                        r_b[l][i+1]   <= r_b[l][i] - db;
                        r_acc[l][i+1] <= r_acc[l][i] + ATAN_TAB[i];
                    end else begin
                        r_a[l][i+1]   <= r_a[l][i] - da;
                        r_b[l][i+1]   <= r_b[l][i] + db;
                        r_acc[l][i+1] <= r_acc[l][i] - ATAN_TAB[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= 1'b0;
        end else if (i_en) begin
            r_fvalid <= r_valid[STAGES];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_round
        logic [ACC_W-1:0] n_sum;

        // round to the output unit by adding half of it first
        assign n_sum = r_acc[l][STAGES] + ACC_ROUND;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ang[l] <= n_sum[ACC_W-1 -: RES_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fside <= r_side[STAGES];
        end
    end

    assign o_valid    = r_fvalid;
    assign o_angle[0] = r_ang[0];
    assign o_angle[1] = r_ang[1];
    assign o_side     = r_fside;

endmodule

// ===== hdl/cartesian_to_spherical.sv =====
`timescale 1ns / 1ps
// Top level of the Cartesian to spherical converter: squares, square roots, CORDIC, output stage.
//
// Converts one point (x, y, z) per item into radius, polar angle theta in [0, pi] and
// azimuth phi in [0, 2pi), angles as binary angles of 2pi/65536. The datapath is a
// single pipeline that takes one item every clock while the skid buffer is empty: four
// front stages (input register, squares, x*x+y*y, full sum), a 33-stage square-root
// pipeline that produces the rounded radius and rho for both lanes together, a
// CORDIC_STAGES+2 deep two-lane vectoring CORDIC (half-plane fold, micro-rotations,
// rounding), then an output register with a one-item skid buffer. Throughput is one
// item per cycle while the skid buffer is empty. The input side only stalls when the
// skid buffer is full: tready low while the output register holds an item and the next
// one arrives is enough to park that item, and the input then holds until the parked
// item moves to the output register. tlast travels with the point unchanged. The
// x = y = 0 and z = 0 cases and the coordinate axes bypass the CORDIC and give exact
// angles.
module cartesian_to_spherical #(
    parameter int COORD_BITS    = c2s_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // slave side
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata from bit 0: coord_x, coord_y, coord_z (COORD_BITS each, signed), zero pad
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    // batch_end
    input  logic                                   i_s_axis_tlast,
    // master side
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // tdata from bit 0: radius, polar_angle, azimuth (16 bits each, unsigned)
    output logic [c2s_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    // batch_end_out
    output logic                                   o_m_axis_tlast
);

    import c2s_pkg::*;

    localparam int CB       = COORD_BITS;
    localparam int SQ_W     = 2 * CB;
    localparam int SCALE_SH = 32 - CB;     // coordinates scaled to 32 bits for the CORDIC
    localparam int NB       = 33;          // square-root result bits
    localparam int VW       = 2 * NB;
    localparam int RAD_K    = NB - CB;     // fraction bits of the radius root
    localparam int RSUM_W   = NB + RES_W + 1;
    localparam int CW       = 35;          // CORDIC x/y width, covers gain and fold

    typedef struct packed {
        logic x_zero;
        logic x_neg;
        logic y_zero;
        logic y_neg;
        logic z_zero;
        logic z_neg;
        logic xy_zero;
    } t_flags;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        t_flags               flags;
        logic                 last;
    } t_pt;

    typedef struct packed {
        logic [RES_W-1:0] radius;
        t_flags           flags;
        logic             last;
    } t_res;

    // global advance: the whole pipeline moves unless the skid buffer is holding an item
    logic w_en;

    // ---------------- stage 1: input register ----------------
    logic                 r1_valid;
    logic signed [CB-1:0] r1_x;
    logic signed [CB-1:0] r1_y;
    logic signed [CB-1:0] r1_z;
    logic                 r1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x    <= i_s_axis_tdata[0 +: CB];
            r1_y    <= i_s_axis_tdata[CB +: CB];
            r1_z    <= i_s_axis_tdata[2*CB +: CB];
            r1_last <= i_s_axis_tlast;
        end
    end

    // ---------------- stage 2: squares and sign/zero flags ----------------
    logic signed [SQ_W-1:0] w_xx;
    logic signed [SQ_W-1:0] w_yy;
    logic signed [SQ_W-1:0] w_zz;
    t_pt                    n2_pt;

    assign w_xx = r1_x * r1_x;
    assign w_yy = r1_y * r1_y;
    assign w_zz = r1_z * r1_z;

    always_comb begin
        n2_pt               = '0;
        n2_pt.x             = r1_x;
        n2_pt.y             = r1_y;
        n2_pt.z             = r1_z;
        n2_pt.last          = r1_last;
        n2_pt.flags.x_zero  = (r1_x == '0);
        n2_pt.flags.x_neg   = r1_x[CB-1];
        n2_pt.flags.y_zero  = (r1_y == '0);
        n2_pt.flags.y_neg   = r1_y[CB-1];
        n2_pt.flags.z_zero  = (r1_z == '0);
        n2_pt.flags.z_neg   = r1_z[CB-1];
        n2_pt.flags.xy_zero = (r1_x == '0) && (r1_y == '0);
    end

    logic            r2_valid;
    logic [SQ_W-1:0] r2_xx;
    logic [SQ_W-1:0] r2_yy;
    logic [SQ_W-1:0] r2_zz;
    t_pt             r2_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_xx <= w_xx;
            r2_yy <= w_yy;
            r2_zz <= w_zz;
            r2_pt <= n2_pt;
        end
    end

    // ---------------- stage 3: x*x + y*y ----------------
    logic            r3_valid;
    logic [SQ_W-1:0] r3_sxy;
    logic [SQ_W-1:0] r3_zz;
    t_pt             r3_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sxy <= r2_xx + r2_yy;
            r3_zz  <= r2_zz;
            r3_pt  <= r2_pt;
        end
    end

    // ---------------- stage 4: full sum of squares ----------------
    logic            r4_valid;
    logic [SQ_W-1:0] r4_s;
    logic [SQ_W-1:0] r4_sxy;
    t_pt             r4_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_s   <= r3_sxy + r3_zz;
            r4_sxy <= r3_sxy;
            r4_pt  <= r3_pt;
        end
    end

    // ---------------- square roots ----------------
    // lane 0: s scaled by 4^RAD_K, so the root carries RAD_K fraction bits for rounding
    // lane 1: rho = floor(sqrt(sxy)) at the CORDIC's 32-bit scale
    logic [VW-1:0]          w_sq_in [2];
    logic                   w_sq_valid;
    logic [NB-1:0]          w_root [2];
    logic [$bits(t_pt)-1:0] w_sq_side;
    t_pt                    w_pt;

    assign w_sq_in[0] = VW'(r4_s) << (2 * RAD_K);
    assign w_sq_in[1] = VW'(r4_sxy) << (2 * SCALE_SH);

    c2s_isqrt #(
        .NB     (NB),
        .SIDE_W ($bits(t_pt))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_valid),
        .i_v     (w_sq_in),
        .i_side  (r4_pt),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    assign w_pt = t_pt'(w_sq_side);

    // round the radius to nearest, halves up
    logic [RSUM_W-1:0] w_rsum;
    t_res              w_res_in;

    assign w_rsum = RSUM_W'(w_root[0]) + (RSUM_W'(1) << (RAD_K - 1));

    always_comb begin
        w_res_in        = '0;
        w_res_in.radius = w_rsum[RAD_K +: RES_W];
        w_res_in.flags  = w_pt.flags;
        w_res_in.last   = w_pt.last;
    end

    // ---------------- CORDIC: lane 0 theta = atan2(rho, z), lane 1 phi = atan2(y, x) ----
    logic signed [CW-1:0]    w_ca [2];
    logic signed [CW-1:0]    w_cb [2];
    logic                    w_cor_valid;
    logic [RES_W-1:0]        w_ang [2];
    logic [$bits(t_res)-1:0] w_cor_side;
    t_res                    w_res;

    assign w_ca[0] = CW'(w_pt.z) <<< SCALE_SH;
    assign w_cb[0] = CW'(w_root[1]);
    assign w_ca[1] = CW'(w_pt.x) <<< SCALE_SH;
    assign w_cb[1] = CW'(w_pt.y) <<< SCALE_SH;

    c2s_cordic #(
        .STAGES (CORDIC_STAGES),
        .CW     (CW),
        .SIDE_W ($bits(t_res))
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_a     (w_ca),
        .i_b     (w_cb),
        .i_side  (w_res_in),
        .o_valid (w_cor_valid),
        .o_angle (w_ang),
        .o_side  (w_cor_side)
    );

    assign w_res = t_res'(w_cor_side);

    // ---------------- exact special cases and theta clamp ----------------
    logic [RES_W-1:0]      w_theta;
    logic [RES_W-1:0]      w_phi;
    logic [OUT_DATA_W-1:0] w_pay;

    always_comb begin
        if (w_res.flags.z_zero) begin
            w_theta = ANG_HALF_PI;
        end else if (w_res.flags.xy_zero) begin
            w_theta = w_res.flags.z_neg ? ANG_PI : ANG_ZERO;
        end else if (w_ang[0] > ANG_PI) begin
            // CORDIC overshoot past 0 or pi: clamp to the nearer end
            w_theta = (w_ang[0] >= ANG_3HALF_PI) ? ANG_ZERO : ANG_PI;
        end else begin
            w_theta = w_ang[0];
        end
    end

    always_comb begin
        if (w_res.flags.y_zero) begin
            w_phi = w_res.flags.x_neg ? ANG_PI : ANG_ZERO;
        end else if (w_res.flags.x_zero) begin
            w_phi = w_res.flags.y_neg ? ANG_3HALF_PI : ANG_HALF_PI;
        end else begin
            w_phi = w_ang[1];
        end
    end

    assign w_pay = {w_phi, w_theta, w_res.radius};

    // ---------------- output register and skid buffer ----------------
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;
    logic                  r_skid_valid;
    logic [OUT_DATA_W-1:0] r_skid_data;
    logic                  r_skid_last;

    assign w_en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            // output slot frees: drain the skid first, otherwise take the pipeline item
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_cor_valid;
            end
        end else if (w_cor_valid && !r_skid_valid) begin
            // output stalled while the pipeline advances: park the item
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_last <= r_skid_last;
            end else begin
                r_out_data <= w_pay;
                r_out_last <= w_res.last;
            end
        end else if (!r_skid_valid) begin
            r_skid_data <= w_pay;
            r_skid_last <= w_res.last;
        end
    end

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // skid only ever holds an item behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid buffer holds an item while the output register is empty");

    // skid fills only out of an output stall
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_axis_tready))
        else $error("skid buffer filled without an output stall");

    // theta stays within 0..pi after the clamp
    a_theta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[2*RES_W-1:RES_W] <= ANG_PI))
        else $error("polar angle beyond pi");
`endif

endmodule
